// File: hdl/e2u_pkg.sv
// Shared types, constants and month-length table for the epoch to UTC calendar block.
package e2u_pkg;

    localparam logic [11:0] BASE_YEAR    = 12'd1970;
    // 1970 mod 4, mod 100 and mod 400
    localparam logic [1:0]  BASE_MOD4    = 2'd2;
    localparam logic [6:0]  BASE_MOD100  = 7'd70;
    localparam logic [8:0]  BASE_MOD400  = 9'd370;
    localparam logic [6:0]  MOD100_LAST  = 7'd99;
    localparam logic [8:0]  MOD400_LAST  = 9'd399;

    localparam logic [6:0]  DIV_60       = 7'd60;
    localparam logic [6:0]  DIV_24       = 7'd24;

    // Reciprocals, exact for any 32-bit dividend:
    // n / 60 = (n * RECIP_60) >> 37, n / 24 = ((n >> 3) * RECIP_3) >> 33
    localparam logic [31:0] RECIP_60     = 32'h8888_8889;
    localparam logic [31:0] RECIP_3      = 32'hAAAA_AAAB;

    localparam logic [8:0]  DAYS_LEAP    = 9'd366;
    localparam logic [8:0]  DAYS_COMMON  = 9'd365;
    localparam logic [3:0]  LAST_MONTH   = 4'd11;
    localparam logic [3:0]  FEB          = 4'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_SEC,
        ST_CAP_SEC,
        ST_DIV_MIN,
        ST_CAP_MIN,
        ST_DIV_HR,
        ST_CAP_HR,
        ST_YEARS,
        ST_MONTHS,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV60,
        OP_DIV24,
        OP_CAP_SEC,
        OP_CAP_MIN,
        OP_CAP_HR,
        OP_YEAR,
        OP_MONTH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } dp_status_t;

    // Zero-based month index, February stretched in leap years
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        begin
            case (m)
                4'd0:    d = 5'd31;
                4'd1:    d = leap ? 5'd29 : 5'd28;
                4'd2:    d = 5'd31;
                4'd3:    d = 5'd30;
                4'd4:    d = 5'd31;
                4'd5:    d = 5'd30;
                4'd6:    d = 5'd31;
                4'd7:    d = 5'd31;
                4'd8:    d = 5'd30;
                4'd9:    d = 5'd31;
                4'd10:   d = 5'd30;
                4'd11:   d = 5'd31;
                default: d = 5'd31;
            endcase
            return d;
        end
    endfunction

endpackage

// File: hdl/e2u_ctrl.sv
// Sequencer that steps the datapath through division, year and month phases.
module e2u_ctrl
    import e2u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    state_t     state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DIV_SEC;
                end
            end
            ST_DIV_SEC:
            begin
                cmd.op     = OP_DIV60;
                state_next = ST_CAP_SEC;
            end
            ST_CAP_SEC:
            begin
                cmd.op     = OP_CAP_SEC;
                state_next = ST_DIV_MIN;
            end
            ST_DIV_MIN:
            begin
                cmd.op     = OP_DIV60;
                state_next = ST_CAP_MIN;
            end
            ST_CAP_MIN:
            begin
                cmd.op     = OP_CAP_MIN;
                state_next = ST_DIV_HR;
            end
            ST_DIV_HR:
            begin
                cmd.op     = OP_DIV24;
                state_next = ST_CAP_HR;
            end
            ST_CAP_HR:
            begin
                cmd.op     = OP_CAP_HR;
                state_next = ST_YEARS;
            end
            ST_YEARS:
            begin
                cmd.op = OP_YEAR;
                if (status.year_done)
                    state_next = ST_MONTHS;
            end
            ST_MONTHS:
            begin
                cmd.op = OP_MONTH;
                if (status.month_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/e2u_dpath.sv
// Datapath: reciprocal constant divider, year and month subtractors, result registers.
module e2u_dpath
    import e2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [31:0] epoch_seconds,
    output dp_status_t  status,
    output logic        not_set,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic [31:0] num_reg;
    logic [30:0] prod_reg;
    logic        zero_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hr_reg;
    logic [15:0] days_reg;
    logic [11:0] year_reg;
    logic [1:0]  mod4_reg;
    logic [6:0]  mod100_reg;
    logic [8:0]  mod400_reg;
    logic [3:0]  mon_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_k;
    logic [26:0] q60;
    logic [30:0] q24;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;
    logic        year_fits;
    logic        mon_fits;

    // One shared 32x32 multiplier; /24 is done as (n >> 3) / 3
    assign mul_a     = (cmd.op == OP_DIV24) ? {3'd0, num_reg[31:3]} : num_reg;
    assign mul_k     = (cmd.op == OP_DIV24) ? RECIP_3 : RECIP_60;
    // prod_reg holds product bits 63:33
    assign q60       = prod_reg[30:4];
    assign q24       = prod_reg;

    assign leap      = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
    assign year_len  = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mon_len   = month_days(mon_reg, leap);
    assign year_fits = (days_reg >= {7'd0, year_len});
    assign mon_fits  = (days_reg >= {11'd0, mon_len}) && (mon_reg != LAST_MONTH);

    assign status.year_done  = !year_fits;
    assign status.month_done = !mon_fits;

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                num_reg <= epoch_seconds;
            end
            OP_DIV60, OP_DIV24:
            begin
                prod_reg <= 31'(({32'd0, mul_a} * {32'd0, mul_k}) >> 33);
            end
            OP_CAP_SEC:
            begin
                sec_reg <= 6'(num_reg - {5'd0, q60} * {25'd0, DIV_60});
                num_reg <= {5'd0, q60};
            end
            OP_CAP_MIN:
            begin
                min_reg <= 6'(num_reg - {5'd0, q60} * {25'd0, DIV_60});
                num_reg <= {5'd0, q60};
            end
            OP_CAP_HR:
            begin
                hr_reg     <= 5'(num_reg - {1'b0, q24} * {25'd0, DIV_24});
                days_reg   <= q24[15:0];
                year_reg   <= BASE_YEAR;
                mod4_reg   <= BASE_MOD4;
                mod100_reg <= BASE_MOD100;
                mod400_reg <= BASE_MOD400;
                mon_reg    <= '0;
            end
            OP_YEAR:
            begin
                if (year_fits)
                begin
                    days_reg   <= days_reg - {7'd0, year_len};
                    year_reg   <= year_reg + 12'd1;
                    mod4_reg   <= mod4_reg + 2'd1;
                    mod100_reg <= (mod100_reg == MOD100_LAST) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_reg <= (mod400_reg == MOD400_LAST) ? 9'd0 : mod400_reg + 9'd1;
                end
            end
            OP_MONTH:
            begin
                if (mon_fits)
                begin
                    days_reg <= days_reg - {11'd0, mon_len};
                    mon_reg  <= mon_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zero_reg <= 1'b0;
        else if (cmd.op == OP_LOAD)
            zero_reg <= (epoch_seconds == 32'd0);
    end

    assign not_set      = zero_reg;
    assign year         = zero_reg ? 12'd0 : year_reg;
    assign month        = zero_reg ? 4'd0  : mon_reg + 4'd1;
    assign day_of_month = zero_reg ? 5'd0  : days_reg[4:0] + 5'd1;
    assign hour         = zero_reg ? 5'd0  : hr_reg;
    assign minute       = zero_reg ? 6'd0  : min_reg;
    assign second       = zero_reg ? 6'd0  : sec_reg;

endmodule

// File: hdl/epoch_to_utc_calendar_top.sv
// Top level of the Unix epoch to UTC calendar converter.
// Sequence from the accepting edge to done: three divisions (multiply and capture for
//   /60, /60, /24), a walk over the years past 1970, then a walk over the months passed.
// Requests: one at a time; busy stays high through the done cycle, so a new request is
//   taken only after done. Result shows for the one cycle done is high.
// Reset: rst_n asynchronously returns the sequencer to idle; done is low during reset.
module epoch_to_utc_calendar_top
    import e2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    output logic        done,
    output logic        not_set,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    // Command from sequencer to datapath, one op per cycle
    dp_cmd_t    cmd;
    // Loop termination flags back from the datapath
    dp_status_t status;

    // Sequencer: load, three constant divisions (/60, /60, /24), year walk, month walk
    e2u_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath: each division is a registered reciprocal multiply, then a capture
    // step that takes quotient and remainder; then one year or one month is
    // subtracted per cycle from the day count.
    // Leap years are tracked with running mod 4/100/400 counters.
    e2u_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .epoch_seconds (epoch_seconds),
        .status        (status),
        .not_set       (not_set),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute),
        .second        (second)
    );

endmodule

// File: hdl/e2u_checker.sv
// Port-level checker for the epoch to UTC calendar converter, bound to the top level.
module e2u_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        not_set,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
);

    // An accepted request makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    // done only while busy, and never high in back-to-back cycles
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while not busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // Unset time gives an all-zero breakdown
    a_not_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && not_set |-> (year == 12'd0) && (month == 4'd0) && (day_of_month == 5'd0)
            && (hour == 5'd0) && (minute == 6'd0) && (second == 6'd0))
        else $error("not_set result has nonzero fields");

    // Valid dates stay in calendar ranges
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        done && !not_set |-> (year >= 12'd1970) && (year <= 12'd2106) && (month >= 4'd1)
            && (month <= 4'd12) && (day_of_month >= 5'd1) && (hour <= 5'd23)
            && (minute <= 6'd59) && (second <= 6'd59))
        else $error("calendar field out of range");

endmodule

bind epoch_to_utc_calendar_top e2u_checker u_e2u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .not_set      (not_set),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
);
